// ----- rtl/ets_pkg.sv -----
// ----------------------------------------------------------------------------
// Expression token scanner package
// Shared types, token kind codes and character constants of the scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int unsigned MAX_LEXEME_DEF = 1022;
  localparam int unsigned LEN_W          = 10;
  localparam int unsigned POS_W          = 16;
  localparam int unsigned FIFO_DEPTH     = 4;
  localparam int unsigned PTR_W          = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W          = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    KIND_VAR     = 4'd0,
    KIND_NUM     = 4'd1,
    KIND_PLUS    = 4'd2,
    KIND_MINUS   = 4'd3,
    KIND_MULT    = 4'd4,
    KIND_DIV     = 4'd5,
    KIND_EXP     = 4'd6,
    KIND_LPAREN  = 4'd7,
    KIND_RPAREN  = 4'd8,
    KIND_SIN     = 4'd9,
    KIND_COS     = 4'd10,
    KIND_TAN     = 4'd11,
    KIND_SQRT    = 4'd12,
    KIND_LN      = 4'd13,
    KIND_EOF     = 4'd14,
    KIND_UNKNOWN = 4'd15
  } kind_t;

  localparam logic [2:0] PREC_NONE  = 3'd0;
  localparam logic [2:0] PREC_ADD   = 3'd1;
  localparam logic [2:0] PREC_MUL   = 3'd2;
  localparam logic [2:0] PREC_POWER = 3'd3;
  localparam logic [2:0] PREC_FUNC  = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // Lowercased names, first letter in the low byte.
  localparam logic [31:0] NAME_SIN  = 32'h006E_6973;
  localparam logic [31:0] NAME_COS  = 32'h0073_6F63;
  localparam logic [31:0] NAME_TAN  = 32'h006E_6174;
  localparam logic [31:0] NAME_SQRT = 32'h7472_7173;
  localparam logic [31:0] NAME_LN   = 32'h0000_6E6C;

  typedef struct packed {
    kind_t             kind;
    logic [2:0]        prec;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic              last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } scan_result_t;

endpackage

// ----- rtl/ets_core.sv -----
// ----------------------------------------------------------------------------
// Expression token scanner core
// Scan state and the per-character step that closes and opens tokens.
// ----------------------------------------------------------------------------
module ets_core #(
  parameter int unsigned MAX_LEXEME = ets_pkg::MAX_LEXEME_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           character,
  output ets_pkg::scan_result_t result
);
  import ets_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEXEME + 1);

  typedef enum logic [1:0] {
    M_IDLE  = 2'd0,
    M_INT   = 2'd1,
    M_FRAC  = 2'd2,
    M_IDENT = 2'd3
  } mode_t;

  mode_t            mode, mode_next;
  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] token_start, token_start_next;
  logic [LW-1:0]    token_length, token_length_next;
  logic [31:0]      name_prefix, name_prefix_next;

  logic        is_dig, is_up, is_alpha, is_sp, taken, eof;
  logic [7:0]  lc;
  logic        close_v, new_v;
  token_t      close_tok, new_tok;
  logic [31:0] len_wide;
  logic [LW-1:0] grown_len;
  logic [31:0]   grown_prefix;

  assign is_dig   = (character >= 8'h30) && (character <= 8'h39);
  assign is_up    = (character >= 8'h41) && (character <= 8'h5A);
  assign is_alpha = is_up || ((character >= 8'h61) && (character <= 8'h7A));
  assign is_sp    = (character == CH_SPACE) || ((character >= 8'h09) && (character <= 8'h0D));
  assign lc       = is_up ? (character | 8'h20) : character;
  assign len_wide = 32'(token_length);

  always_comb begin
    grown_len = (token_length < LW'(MAX_LEXEME)) ? token_length + LW'(1) : token_length;
    grown_prefix = name_prefix;
    if (mode == M_IDENT && token_length < LW'(4)) begin
      case (token_length[1:0])
        2'd0: grown_prefix[7:0]   = lc;
        2'd1: grown_prefix[15:8]  = lc;
        2'd2: grown_prefix[23:16] = lc;
        default: grown_prefix[31:24] = lc;
      endcase
    end
  end

  always_comb begin
    mode_next         = mode;
    position_next     = position;
    token_start_next  = token_start;
    token_length_next = token_length;
    name_prefix_next  = name_prefix;
    taken     = 1'b0;
    eof       = 1'b0;
    close_v   = 1'b0;
    new_v     = 1'b0;
    close_tok = '0;
    new_tok   = '0;
    close_tok.start = token_start;
    close_tok.len   = len_wide[LEN_W-1:0];
    close_tok.kind  = KIND_VAR;
    close_tok.prec  = PREC_NONE;

    case (mode)
      M_INT, M_FRAC: begin
        if (is_dig || (character == CH_DOT && mode == M_INT)) begin
          token_length_next = grown_len;
          taken = 1'b1;
          if (!is_dig) mode_next = M_FRAC;
        end else begin
          close_v = 1'b1;
          close_tok.kind = KIND_NUM;
          mode_next = M_IDLE;
        end
      end
      M_IDENT: begin
        if (is_alpha) begin
          token_length_next = grown_len;
          name_prefix_next  = grown_prefix;
          taken = 1'b1;
        end else begin
          close_v = 1'b1;
          mode_next = M_IDLE;
          if (character == CH_LPAREN) begin
            close_tok.kind = KIND_UNKNOWN;
            close_tok.prec = PREC_FUNC;
            if (token_length == LW'(3) && name_prefix == NAME_SIN) close_tok.kind = KIND_SIN;
            else if (token_length == LW'(3) && name_prefix == NAME_COS) close_tok.kind = KIND_COS;
            else if (token_length == LW'(3) && name_prefix == NAME_TAN) close_tok.kind = KIND_TAN;
            else if (token_length == LW'(4) && name_prefix == NAME_SQRT)
              close_tok.kind = KIND_SQRT;
            else if (token_length == LW'(2) && name_prefix == NAME_LN) close_tok.kind = KIND_LN;
            else close_tok.prec = PREC_NONE;
          end
        end
      end
      default: ;
    endcase

    if (!taken) begin
      if (character == CH_NUL) begin
        // End of expression: report eof at the current position and start over.
        eof = 1'b1;
        new_v = 1'b1;
        new_tok.kind  = KIND_EOF;
        new_tok.start = position;
        mode_next         = M_IDLE;
        position_next     = '0;
        token_start_next  = '0;
        token_length_next = '0;
        name_prefix_next  = '0;
      end else if (!is_sp) begin
        token_start_next  = position;
        token_length_next = LW'(1);
        name_prefix_next  = '0;
        if (is_dig) begin
          mode_next = M_INT;
        end else if (is_alpha) begin
          mode_next = M_IDENT;
          name_prefix_next = {24'd0, lc};
        end else begin
          new_v = 1'b1;
          new_tok.start = position;
          new_tok.len   = LEN_W'(1);
          new_tok.prec  = PREC_NONE;
          token_length_next = '0;
          case (character)
            CH_PLUS:   begin new_tok.kind = KIND_PLUS;  new_tok.prec = PREC_ADD;   end
            CH_MINUS:  begin new_tok.kind = KIND_MINUS; new_tok.prec = PREC_ADD;   end
            CH_STAR:   begin new_tok.kind = KIND_MULT;  new_tok.prec = PREC_MUL;   end
            CH_SLASH:  begin new_tok.kind = KIND_DIV;   new_tok.prec = PREC_MUL;   end
            CH_CARET:  begin new_tok.kind = KIND_EXP;   new_tok.prec = PREC_POWER; end
            CH_LPAREN: new_tok.kind = KIND_LPAREN;
            CH_RPAREN: new_tok.kind = KIND_RPAREN;
            default:   new_tok.kind = KIND_UNKNOWN;
          endcase
        end
      end
    end

    if (!eof && position != {POS_W{1'b1}}) position_next = position + POS_W'(1);

    close_tok.last = !new_v;
    new_tok.last   = 1'b1;
  end

  // The first slot always carries the earlier result.
  always_comb begin
    result.count  = {1'b0, close_v} + {1'b0, new_v};
    result.first  = close_v ? close_tok : new_tok;
    result.second = new_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      position     <= '0;
      token_start  <= '0;
      token_length <= '0;
      name_prefix  <= '0;
    end else if (step) begin
      mode         <= mode_next;
      position     <= position_next;
      token_start  <= token_start_next;
      token_length <= token_length_next;
      name_prefix  <= name_prefix_next;
    end
  end

  a_open_token_has_length: assert property (@(posedge clk) disable iff (rst)
    mode != M_IDLE |-> token_length != '0)
    else $error("open token with zero length");

  a_eof_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && eof) |=> (position == '0 && mode == M_IDLE))
    else $error("scanner did not restart after end of expression");

  a_prefix_unfilled_byte: assert property (@(posedge clk) disable iff (rst)
    (mode == M_IDENT && token_length < LW'(4)) |-> name_prefix[31:24] == 8'd0)
    else $error("name prefix holds a letter beyond the identifier length");

endmodule

// ----- rtl/expression_token_scanner.sv -----
// ----------------------------------------------------------------------------
// Expression token scanner
// Splits a byte stream holding an arithmetic expression into tokens.
// ----------------------------------------------------------------------------
// The scanner takes one character per cycle while char_stall is low. A character
// is held in an input register and processed from there into up to two results,
// which go into a four-entry result queue; the queue hands out one token per cycle
// while token_stall is low. A character that closes a token and also forms one of
// its own therefore takes two queue entries, and the input stalls only while the
// queue has fewer than two free entries. A byte of zero ends the expression: it
// closes any open token, gives an eof token and resets the position to zero.
module expression_token_scanner #(
  parameter int unsigned MAX_LEXEME = ets_pkg::MAX_LEXEME_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        char_valid,
  output logic                        char_stall,
  input  logic [7:0]                  character,
  output logic                        token_valid,
  input  logic                        token_stall,
  output logic [3:0]                  token_kind,
  output logic [2:0]                  precedence,
  output logic [ets_pkg::POS_W-1:0]   start_offset,
  output logic [ets_pkg::LEN_W-1:0]   lexeme_length,
  output logic                        last
);
  import ets_pkg::*;

  logic         held;
  logic [7:0]   held_char;
  logic         proc, accept, pop;
  scan_result_t res;
  logic [1:0]   push;

  token_t             queue [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  token_t             head;

  ets_core #(.MAX_LEXEME(MAX_LEXEME)) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (proc),
    .character (held_char),
    .result    (res)
  );

  assign proc       = held && (count <= CNT_W'(FIFO_DEPTH - 2));
  assign char_stall = held && !proc;
  assign accept     = char_valid && !char_stall;
  assign pop        = token_valid && !token_stall;
  assign push       = proc ? res.count : 2'd0;

  assign head          = queue[rd_ptr];
  assign token_valid   = count != '0;
  assign token_kind    = head.kind;
  assign precedence    = head.prec;
  assign start_offset  = head.start;
  assign lexeme_length = head.len;
  assign last          = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      held   <= accept || (held && !proc);
      wr_ptr <= wr_ptr + PTR_W'(push);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_char <= character;
  end

  always_ff @(posedge clk) begin
    if (push != 2'd0) queue[wr_ptr] <= res.first;
    if (push == 2'd2) queue[wr_ptr + PTR_W'(1)] <= res.second;
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_pointer_match: assert property (@(posedge clk) disable iff (rst)
    PTR_W'(wr_ptr - rd_ptr) == count[PTR_W-1:0])
    else $error("queue pointers disagree with fill count");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!proc && !pop) |=> $stable(count))
    else $error("fill count changed with no transaction");

endmodule
